[rtl/nss_pkg.sv]
`timescale 1ns / 1ps

package nss_pkg;

   localparam int MAX_RANKS  = 64;
   localparam int MAX_SLICES = 32;

   localparam int RANK_W  = 7;
   localparam int POS_W   = 6;
   localparam int STEP_W  = 3;
   localparam int ROLE_W  = 2;
   localparam int TOTAL_W = 6;
   localparam int CSR_W   = 7;
   localparam int INDEX_W = 2;

   localparam logic [INDEX_W-1:0] CSR_RANK_COUNT    = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_MY_POSITION   = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_ROOT_POSITION = 2'd2;
   localparam logic [INDEX_W-1:0] CSR_STEP_COUNT    = 2'd3;

   localparam logic [ROLE_W-1:0] ROLE_NONE    = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_SEND    = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_RECEIVE = 2'd2;

   typedef struct packed {
      logic              load;
      logic              mod_en;
      logic              dbl_en;
      logic              plan;
      logic              show;
      logic [STEP_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic dbl_done;
      logic final_beat;
   } status_type;

endpackage

[rtl/nss_datapath.sv]
`timescale 1ns / 1ps

module nss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [nss_pkg::INDEX_W-1:0]   csr_index,
   input  logic [nss_pkg::CSR_W-1:0]     csr_write_data,
   input  logic [nss_pkg::STEP_W-1:0]    req_step,
   input  nss_pkg::cmd_type              cmd,
   output nss_pkg::status_type           status,
   output logic [nss_pkg::ROLE_W-1:0]    rsp_role,
   output logic [nss_pkg::POS_W-1:0]     rsp_peer_position,
   output logic [nss_pkg::POS_W-1:0]     rsp_slice_index,
   output logic [nss_pkg::TOTAL_W-1:0]   rsp_slice_total,
   output logic                          rsp_last
);

   logic [nss_pkg::RANK_W-1:0]  rank_count_ff, rank_count_in;
   logic [nss_pkg::POS_W-1:0]   my_cfg_ff, my_cfg_in;
   logic [nss_pkg::POS_W-1:0]   root_cfg_ff, root_cfg_in;
   logic [nss_pkg::STEP_W-1:0]  step_count_ff, step_count_in;

   logic [nss_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [nss_pkg::RANK_W-1:0]  n_ff, n_in;
   logic [nss_pkg::POS_W-1:0]   my_ff, my_in;
   logic [nss_pkg::POS_W-1:0]   root_ff, root_in;
   logic [nss_pkg::POS_W-1:0]   dn_ff, dn_in;
   logic [nss_pkg::POS_W-1:0]   stride_ff, stride_in;
   logic [nss_pkg::ROLE_W-1:0]  role_ff, role_in;
   logic [nss_pkg::POS_W-1:0]   peer_ff, peer_in;
   logic [nss_pkg::POS_W-1:0]   idx_ff, idx_in;
   logic [nss_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [nss_pkg::TOTAL_W-1:0] remain_ff, remain_in;

   logic [nss_pkg::ROLE_W-1:0]  out_role_ff, out_role_in;
   logic [nss_pkg::POS_W-1:0]   out_peer_ff, out_peer_in;
   logic [nss_pkg::POS_W-1:0]   out_idx_ff, out_idx_in;
   logic [nss_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic                        out_last_ff, out_last_in;

   logic [nss_pkg::RANK_W-1:0]  n_clamp;
   logic [nss_pkg::RANK_W-1:0]  my_shift, root_shift, dbl_val, dbl_mod;
   logic [7:0]                  d_val, span, delta_sum, delta, slice_sum, slice_shift;
   logic [8:0]                  span_d;
   logic                        perfect, last_step, is_send, is_recv;
   logic [nss_pkg::RANK_W-1:0]  send_sum, recv_sum, adv_sum;
   logic [nss_pkg::POS_W-1:0]   send_peer, recv_peer, adv_idx;
   logic [nss_pkg::TOTAL_W-1:0] nslices;

   always_comb begin
      rank_count_in = rank_count_ff;
      my_cfg_in     = my_cfg_ff;
      root_cfg_in   = root_cfg_ff;
      step_count_in = step_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            nss_pkg::CSR_RANK_COUNT:    rank_count_in = csr_write_data;
            nss_pkg::CSR_MY_POSITION:   my_cfg_in     = csr_write_data[nss_pkg::POS_W-1:0];
            nss_pkg::CSR_ROOT_POSITION: root_cfg_in   = csr_write_data[nss_pkg::POS_W-1:0];
            nss_pkg::CSR_STEP_COUNT:    step_count_in = csr_write_data[nss_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rank_count_ff == '0) begin
         n_clamp = nss_pkg::RANK_W'(1);
      end else if (rank_count_ff > nss_pkg::RANK_W'(nss_pkg::MAX_RANKS)) begin
         n_clamp = nss_pkg::RANK_W'(nss_pkg::MAX_RANKS);
      end else begin
         n_clamp = rank_count_ff;
      end

      my_shift   = {my_ff, my_cfg_ff[cmd.count]};
      root_shift = {root_ff, root_cfg_ff[cmd.count]};
      if (my_shift >= n_ff) my_shift = my_shift - n_ff;
      if (root_shift >= n_ff) root_shift = root_shift - n_ff;

      dbl_val = {dn_ff, 1'b0};
      dbl_mod = (dbl_val >= n_ff) ? dbl_val - n_ff : dbl_val;

      d_val     = 8'd1 << step_ff;
      perfect   = (n_ff & (n_ff - nss_pkg::RANK_W'(1))) == '0;
      last_step = ({1'b0, step_ff} + 4'd1) == {1'b0, step_count_ff};
      if (!perfect && last_step) begin
         span = ({1'b0, n_ff} > d_val) ? {1'b0, n_ff} - d_val : 8'd0;
      end else begin
         span = d_val;
      end
      span_d = {1'b0, span} + {1'b0, d_val};

      delta_sum = {2'b0, root_ff} + {1'b0, n_ff} - {2'b0, my_ff};
      delta     = (delta_sum >= {1'b0, n_ff}) ? delta_sum - {1'b0, n_ff} : delta_sum;
      is_send   = delta < span;
      is_recv   = !is_send && (delta >= d_val) && ({1'b0, delta} < span_d);

      send_sum  = {1'b0, my_ff} + n_ff - {1'b0, dn_ff};
      send_peer = (send_sum >= n_ff) ? nss_pkg::POS_W'(send_sum - n_ff)
                                     : nss_pkg::POS_W'(send_sum);
      recv_sum  = {1'b0, my_ff} + {1'b0, dn_ff};
      recv_peer = (recv_sum >= n_ff) ? nss_pkg::POS_W'(recv_sum - n_ff)
                                     : nss_pkg::POS_W'(recv_sum);

      slice_sum   = {1'b0, n_ff} - 8'd1 + d_val;
      slice_shift = slice_sum >> ({1'b0, step_ff} + 4'd1);
      nslices     = (slice_shift > 8'(nss_pkg::MAX_SLICES))
                    ? nss_pkg::TOTAL_W'(nss_pkg::MAX_SLICES)
                    : slice_shift[nss_pkg::TOTAL_W-1:0];

      adv_sum = {1'b0, idx_ff} + n_ff - {1'b0, stride_ff};
      adv_idx = (adv_sum >= n_ff) ? nss_pkg::POS_W'(adv_sum - n_ff)
                                  : nss_pkg::POS_W'(adv_sum);
   end

   always_comb begin
      step_in      = step_ff;
      n_in         = n_ff;
      my_in        = my_ff;
      root_in      = root_ff;
      dn_in        = dn_ff;
      stride_in    = stride_ff;
      role_in      = role_ff;
      peer_in      = peer_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      remain_in    = remain_ff;
      out_role_in  = out_role_ff;
      out_peer_in  = out_peer_ff;
      out_idx_in   = out_idx_ff;
      out_total_in = out_total_ff;
      out_last_in  = out_last_ff;

      if (cmd.load) begin
         step_in = req_step;
         n_in    = n_clamp;
         my_in   = '0;
         root_in = '0;
         dn_in   = (n_clamp > nss_pkg::RANK_W'(1)) ? nss_pkg::POS_W'(1) : '0;
      end
      if (cmd.mod_en) begin
         my_in   = my_shift[nss_pkg::POS_W-1:0];
         root_in = root_shift[nss_pkg::POS_W-1:0];
      end
      if (cmd.dbl_en) begin
         if (status.dbl_done) begin
            stride_in = dbl_mod[nss_pkg::POS_W-1:0];
         end else begin
            dn_in = dbl_mod[nss_pkg::POS_W-1:0];
         end
      end
      if (cmd.plan) begin
         if ((is_send || is_recv) && nslices != '0) begin
            role_in   = is_send ? nss_pkg::ROLE_SEND : nss_pkg::ROLE_RECEIVE;
            peer_in   = is_send ? send_peer : recv_peer;
            idx_in    = is_send ? send_peer : my_ff;
            total_in  = nslices;
            remain_in = nslices;
         end else begin
            role_in   = nss_pkg::ROLE_NONE;
            peer_in   = '0;
            idx_in    = '0;
            total_in  = '0;
            remain_in = nss_pkg::TOTAL_W'(1);
            stride_in = '0;
         end
      end
      if (cmd.show) begin
         out_role_in  = role_ff;
         out_peer_in  = peer_ff;
         out_idx_in   = idx_ff;
         out_total_in = total_ff;
         out_last_in  = status.final_beat;
         idx_in       = adv_idx;
         remain_in    = remain_ff - nss_pkg::TOTAL_W'(1);
      end
   end

   assign status.dbl_done   = cmd.count == step_ff;
   assign status.final_beat = remain_ff == nss_pkg::TOTAL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff <= nss_pkg::RANK_W'(1);
         my_cfg_ff     <= '0;
         root_cfg_ff   <= '0;
         step_count_ff <= '0;
      end else begin
         rank_count_ff <= rank_count_in;
         my_cfg_ff     <= my_cfg_in;
         root_cfg_ff   <= root_cfg_in;
         step_count_ff <= step_count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      n_ff         <= n_in;
      my_ff        <= my_in;
      root_ff      <= root_in;
      dn_ff        <= dn_in;
      stride_ff    <= stride_in;
      role_ff      <= role_in;
      peer_ff      <= peer_in;
      idx_ff       <= idx_in;
      total_ff     <= total_in;
      remain_ff    <= remain_in;
      out_role_ff  <= out_role_in;
      out_peer_ff  <= out_peer_in;
      out_idx_ff   <= out_idx_in;
      out_total_ff <= out_total_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_role          = out_role_ff;
   assign rsp_peer_position = out_peer_ff;
   assign rsp_slice_index   = out_idx_ff;
   assign rsp_slice_total   = out_total_ff;
   assign rsp_last          = out_last_ff;

endmodule

[rtl/nss_ctrl.sv]
`timescale 1ns / 1ps

module nss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  nss_pkg::status_type  status,
   output nss_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_DBL  = 5'b00100,
      ST_PLAN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [nss_pkg::STEP_W-1:0]  count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.count    = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = nss_pkg::STEP_W'(nss_pkg::POS_W - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_en = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_DBL;
            end else begin
               count_in = count_ff - nss_pkg::STEP_W'(1);
            end
         end
         ST_DBL: begin
            cmd.dbl_en = 1'b1;
            if (status.dbl_done) begin
               state_in = ST_PLAN;
            end else begin
               count_in = count_ff + nss_pkg::STEP_W'(1);
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.show     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.final_beat) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_MOD)
      else $error("Accepted request did not start the remainder phase.");

   a_show_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.show |-> out_free)
      else $error("Result beat loaded over one still waiting.");

   a_final_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.show && status.final_beat |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("Final beat did not return the controller to idle.");

   a_mod_to_dbl: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD && count_ff == '0 |=> state_ff == ST_DBL)
      else $error("Remainder phase ran past its last bit.");

endmodule

[rtl/nhr_scatter_step_schedule.sv]
// After a request is accepted the controller runs six remainder iterations for the positions,
// step + 1 doubling iterations and a planning state before the first result beat loads.
// Then one beat per cycle for each slice while rsp_stall does not hold the output (one beat when
// the rank has no role); the next request is accepted after the last beat loads.
// Reset clears the controller and result valid and returns the CSR registers to their reset values.
`timescale 1ns / 1ps

module nhr_scatter_step_schedule (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [nss_pkg::INDEX_W-1:0]   csr_index,
   input  logic [nss_pkg::CSR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nss_pkg::STEP_W-1:0]    req_step,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nss_pkg::ROLE_W-1:0]    rsp_role,
   output logic [nss_pkg::POS_W-1:0]     rsp_peer_position,
   output logic [nss_pkg::POS_W-1:0]     rsp_slice_index,
   output logic [nss_pkg::TOTAL_W-1:0]   rsp_slice_total,
   output logic                          rsp_last
);

   nss_pkg::cmd_type    cmd;
   nss_pkg::status_type status;

   nss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nss_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_step          (req_step),
      .cmd               (cmd),
      .status            (status),
      .rsp_role          (rsp_role),
      .rsp_peer_position (rsp_peer_position),
      .rsp_slice_index   (rsp_slice_index),
      .rsp_slice_total   (rsp_slice_total),
      .rsp_last          (rsp_last)
   );

endmodule
